// ===== sv/aip_pkg.sv =====
`timescale 1ns / 1ps

package aip_pkg;

   // Character codes the parser reacts to
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharLowerX = 8'h78;
   localparam logic [7:0] CharUpperX = 8'h58;
   localparam logic [7:0] CharMinus  = 8'h2D;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperF = 8'h46;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerF = 8'h66;
   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharTab    = 8'h09;
   localparam logic [7:0] CharCr     = 8'h0D;

   localparam int unsigned DecBase = 10;

   typedef struct packed {
      logic [7:0] char_in;
      logic       start_new;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] number;
      logic [7:0]         used_count;
   } rsp_type;

endpackage

// ===== sv/ascii_integer_parser_unit.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Beat payload
// --------+-----------+------------------------+---------------------------------------
// req     | in        | req_valid / req_ready  | req_data : char_in, start_new
// rsp     | out       | rsp_valid / rsp_ready  | rsp_data : found, number, used_count
//
// One byte is taken every cycle while req_ready is high; the parse state updates
// in the cycle of the beat. A result reaches rsp from the result register.
// The byte-to-state path is one multiply-by-ten (two shifts and a three-input add).
// A result register plus one skid entry part the two sides; req_ready is registered
// and drops only while both hold a result.
// Reset (synchronous, active high) returns the parser to idle and empties both entries.

module ascii_integer_parser_unit #(
   parameter int COUNT_MAX = 255
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  aip_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output aip_pkg::rsp_type rsp_data
);
   import aip_pkg::*;

   // Consumed count stops at the smaller of the parameter and the field's top
   localparam int         CntTopInt = (COUNT_MAX < 255) ? COUNT_MAX : 255;
   localparam logic [7:0] CntTop    = CntTopInt[7:0];
   localparam logic [3:0] HexNone   = 4'd0;
   localparam logic [3:0] HexTen    = 4'(DecBase);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WS,
      PH_SIGN,
      PH_ZERO,
      PH_DEC,
      PH_HEX
   } phase_type;

   // Parse state
   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic [7:0]  cnt_ff, cnt_in;

   // Result register and skid entry
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_data_ff, out_data_in;
   logic        skid_valid_ff, skid_valid_in;
   rsp_type     skid_data_ff, skid_data_in;

   // Per-byte decode
   logic        req_fire;
   logic        rsp_fire;
   logic [7:0]  ch;
   logic        is_ws;
   logic        is_dec;
   logic        is_hex;
   logic [3:0]  hex_val;
   logic [31:0] dec_next;
   logic [31:0] hex_next;
   logic [7:0]  cnt_take;

   // Effective state after an optional restart
   phase_type   phase_cur;
   logic [31:0] acc_cur;
   logic        neg_cur;
   logic [7:0]  cnt_cur;

   // Result produced by this beat
   logic        res_hit;
   logic        res_fire;
   rsp_type     res_data;

   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign rsp_fire  = out_valid_ff && rsp_ready;
   assign ch        = req_data.char_in;

   always_comb begin
      is_ws   = (ch == CharSpace) || (ch inside {[CharTab:CharCr]});
      is_dec  = ch inside {[CharZero:CharNine]};
      is_hex  = 1'b1;
      hex_val = HexNone;
      if (is_dec) begin
         hex_val = 4'(ch - CharZero);
      end else if (ch inside {[CharUpperA:CharUpperF]}) begin
         hex_val = 4'(ch - CharUpperA) + HexTen;
      end else if (ch inside {[CharLowerA:CharLowerF]}) begin
         hex_val = 4'(ch - CharLowerA) + HexTen;
      end else begin
         is_hex = 1'b0;
      end
   end

   always_comb begin
      // Restart: drop any parse in progress
      if (req_data.start_new) begin
         phase_cur = PH_WS;
         acc_cur   = '0;
         neg_cur   = 1'b0;
         cnt_cur   = '0;
      end else begin
         phase_cur = phase_ff;
         acc_cur   = acc_ff;
         neg_cur   = neg_ff;
         cnt_cur   = cnt_ff;
      end

      // Times ten as (x << 3) + (x << 1), wrapping at 32 bits
      dec_next = {acc_cur[28:0], 3'b000} + {acc_cur[30:0], 1'b0} + {28'd0, hex_val};
      hex_next = {acc_cur[27:0], hex_val};
      cnt_take = (cnt_cur < CntTop) ? cnt_cur + 8'd1 : cnt_cur;

      phase_in = phase_cur;
      acc_in   = acc_cur;
      neg_in   = neg_cur;
      cnt_in   = cnt_cur;
      res_fire = 1'b0;
      res_hit  = 1'b0;

      case (phase_cur)
         PH_WS: begin
            if (is_ws) begin
               cnt_in = cnt_take;
            end else if (ch == CharMinus) begin
               neg_in   = 1'b1;
               cnt_in   = cnt_take;
               phase_in = PH_SIGN;
            end else if (ch == CharZero) begin
               acc_in   = '0;
               cnt_in   = cnt_take;
               phase_in = PH_ZERO;
            end else if (is_dec) begin
               acc_in   = {28'd0, hex_val};
               cnt_in   = cnt_take;
               phase_in = PH_DEC;
            end else begin
               res_fire = 1'b1;
            end
         end
         PH_SIGN: begin
            if (ch == CharZero) begin
               acc_in   = '0;
               cnt_in   = cnt_take;
               phase_in = PH_ZERO;
            end else if (is_dec) begin
               acc_in   = {28'd0, hex_val};
               cnt_in   = cnt_take;
               phase_in = PH_DEC;
            end else begin
               res_fire = 1'b1;
               res_hit  = 1'b1;
            end
         end
         PH_ZERO: begin
            if ((ch == CharLowerX) || (ch == CharUpperX)) begin
               cnt_in   = cnt_take;
               phase_in = PH_HEX;
            end else if (is_dec) begin
               acc_in   = dec_next;
               cnt_in   = cnt_take;
               phase_in = PH_DEC;
            end else begin
               res_fire = 1'b1;
               res_hit  = 1'b1;
            end
         end
         PH_DEC: begin
            if (is_dec) begin
               acc_in = dec_next;
               cnt_in = cnt_take;
            end else begin
               res_fire = 1'b1;
               res_hit  = 1'b1;
            end
         end
         PH_HEX: begin
            if (is_hex) begin
               acc_in = hex_next;
               cnt_in = cnt_take;
            end else begin
               res_fire = 1'b1;
               res_hit  = 1'b1;
            end
         end
         default: begin
            // Idle: ignore bytes until one arrives marked start_new
            phase_in = PH_IDLE;
         end
      endcase

      // Ending byte is not consumed; go back to idle
      if (res_fire) begin
         phase_in = PH_IDLE;
      end

      res_data.found      = res_hit;
      res_data.number     = res_hit ? (neg_cur ? 32'd0 - acc_cur : acc_cur) : '0;
      res_data.used_count = cnt_cur;
   end

   // Output side: result register backed by one skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // Input is held off; drain the skid entry once the output frees up
         if (rsp_fire) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || rsp_fire) begin
         out_valid_in = req_fire && res_fire;
         if (req_fire && res_fire) begin
            out_data_in = res_data;
         end
      end else if (req_fire && res_fire) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff <= phase_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      // Payload needs no reset: a restart clears it before use
      if (req_fire) begin
         acc_ff <= acc_in;
         neg_ff <= neg_in;
         cnt_ff <= cnt_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ===== sv/aip_checker.sv =====
`timescale 1ns / 1ps

module aip_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input aip_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input aip_pkg::rsp_type rsp_data
);
   import aip_pkg::*;

   // Leave reset with nothing pending and room for a beat
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("result pending or input blocked after reset");

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result beat changed while stalled");

   // No number, no value
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.number == 32'sd0))
      else $error("nonzero value on a miss");

   // A hit always consumed at least a sign or a digit
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> (rsp_data.used_count != 8'd0))
      else $error("hit reported with nothing consumed");

endmodule

bind ascii_integer_parser_unit aip_checker u_aip_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/aip_result_checker.sv =====
`timescale 1ns / 1ps

module aip_result_checker #(
   parameter int COUNT_MAX = 255
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  aip_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  aip_pkg::rsp_type rsp_data,
   output int unsigned      mismatch_count,
   output int unsigned      outstanding
);
   import aip_pkg::*;

   localparam logic [7:0] CountTop = (COUNT_MAX < 255) ? 8'(COUNT_MAX) : 8'd255;

   typedef enum logic [2:0] {
      ScanIdle, ScanSpace, ScanSign, ScanZero, ScanDec, ScanHex
   } scan_phase_type;

   scan_phase_type phase = ScanIdle;
   logic [31:0]    value_acc = '0;
   logic           minus_seen = 1'b0;
   logic [7:0]     bytes_taken = '0;
   rsp_type        expected_numbers[$];
   int unsigned    result_index = 0;
   int unsigned    errors = 0;

   function automatic bit is_space(input logic [7:0] c);
      return c == CharSpace || (c >= CharTab && c <= CharCr);
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= CharZero && c <= CharNine;
   endfunction

   // 16 marks a byte that is no hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (is_digit(c)) return 5'(c - CharZero);
      if (c >= CharUpperA && c <= CharUpperF) return 5'(c - CharUpperA + 8'd10);
      if (c >= CharLowerA && c <= CharLowerF) return 5'(c - CharLowerA + 8'd10);
      return 5'd16;
   endfunction

   function void count_byte();
      if (bytes_taken < CountTop) bytes_taken++;
   endfunction

   function rsp_type close_parse(input bit hit);
      rsp_type r;
      r.found      = hit;
      r.number     = hit ? (minus_seen ? 32'd0 - value_acc : value_acc) : 32'd0;
      r.used_count = bytes_taken;
      phase        = ScanIdle;
      return r;
   endfunction

   // Advance the parser by one byte; return 1 when the byte ends the parse
   function bit parse_step(input req_type beat, output rsp_type outcome);
      logic [7:0] c;
      logic [4:0] hv;
      c       = beat.char_in;
      hv      = hex_digit(c);
      outcome = '0;
      if (beat.start_new) begin
         phase       = ScanSpace;
         value_acc   = '0;
         minus_seen  = 1'b0;
         bytes_taken = '0;
      end
      case (phase)
         ScanSpace: begin
            if (is_space(c)) begin
               count_byte();
               return 1'b0;
            end
            if (c == CharMinus) begin
               minus_seen = 1'b1;
               count_byte();
               phase = ScanSign;
               return 1'b0;
            end
            if (is_digit(c)) begin
               value_acc = 32'(c - CharZero);
               count_byte();
               phase = (c == CharZero) ? ScanZero : ScanDec;
               return 1'b0;
            end
            outcome = close_parse(1'b0);
            return 1'b1;
         end
         ScanSign: begin
            if (is_digit(c)) begin
               value_acc = 32'(c - CharZero);
               count_byte();
               phase = (c == CharZero) ? ScanZero : ScanDec;
               return 1'b0;
            end
            outcome = close_parse(1'b1);
            return 1'b1;
         end
         ScanZero, ScanDec: begin
            if (phase == ScanZero && (c == CharLowerX || c == CharUpperX)) begin
               count_byte();
               phase = ScanHex;
               return 1'b0;
            end
            if (is_digit(c)) begin
               value_acc = value_acc * 32'(DecBase) + 32'(c - CharZero);
               count_byte();
               phase = ScanDec;
               return 1'b0;
            end
            outcome = close_parse(1'b1);
            return 1'b1;
         end
         ScanHex: begin
            if (hv < 5'd16) begin
               value_acc = {value_acc[27:0], hv[3:0]};
               count_byte();
               return 1'b0;
            end
            outcome = close_parse(1'b1);
            return 1'b1;
         end
         default: begin
            phase = ScanIdle;
            return 1'b0;
         end
      endcase
   endfunction

   function void flag_error(input string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endfunction

   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type want;
      if (reset) begin
         phase       = ScanIdle;
         value_acc   = '0;
         minus_seen  = 1'b0;
         bytes_taken = '0;
         expected_numbers.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_numbers.size() == 0) begin
               flag_error($sformatf("result %0d: unexpected beat found=%0b number=%0d used=%0d",
                                    result_index, rsp_data.found, rsp_data.number,
                                    rsp_data.used_count));
            end else begin
               want = expected_numbers.pop_front();
               if (rsp_data.found !== want.found)
                  flag_error($sformatf("result %0d: found expected %0b, got %0b",
                                       result_index, want.found, rsp_data.found));
               if (rsp_data.number !== want.number)
                  flag_error($sformatf("result %0d: number expected %0d, got %0d",
                                       result_index, want.number, rsp_data.number));
               if (rsp_data.used_count !== want.used_count)
                  flag_error($sformatf("result %0d: used_count expected %0d, got %0d",
                                       result_index, want.used_count, rsp_data.used_count));
            end
            result_index++;
         end
         if (req_valid && req_ready && parse_step(req_data, predicted))
            expected_numbers.push_back(predicted);
      end
      mismatch_count <= errors;
      outstanding    <= expected_numbers.size();
   end

endmodule

// ===== tb/sv/ascii_integer_parser_unit_tb.sv =====
`timescale 1ns / 1ps

module ascii_integer_parser_unit_tb;
   import aip_pkg::*;

   localparam int CountMax       = 255;
   localparam int TextBeats      = 550;
   localparam int CalmBeats      = 60;
   localparam int HoldCycles     = 60;
   localparam int DrainLimit     = 2000;
   localparam int SettleCycles   = 10;
   localparam int SaturateSpaces = 270;

   typedef enum logic [1:0] {FormBare, FormDec, FormHex, FormZero} number_form_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   int unsigned mismatch_count;
   int unsigned outstanding;

   int unsigned beats_sent;
   bit          calm;       // last stretch of the run: no idling on either side
   bit          hold_rsp;   // raised by the sender, cleared by the receiver after the hold
   bit          gaps_on;
   logic [7:0]  text_buf[$];

   ascii_integer_parser_unit #(
      .COUNT_MAX(CountMax)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Watch both channels, predict every result and compare it
   aip_result_checker #(
      .COUNT_MAX(CountMax)
   ) parse_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // Receiver: alternate ready stretches and stall bursts; on request, hold off
   // long enough that the result buffer fills and req_ready drops.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles - 1) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(16, 40) : $urandom_range(0, 15))
               @(posedge clock);
         end
      end
   end

   // Offer one beat and hold it until accepted; valid stays high on return so that
   // back-to-back beats never drop it within a step.
   task automatic send_beat(input logic [7:0] ch, input logic first, input bit counted);
      if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_in: ch, start_new: first};
      do @(posedge clock); while (!req_ready);
      if (counted) beats_sent++;
   endtask

   // Send the buffered text as one parse: the first byte restarts the parser
   task automatic send_text();
      foreach (text_buf[i]) send_beat(text_buf[i], i == 0, 1'b1);
   endtask

   // A byte that ends a parse in any phase: never whitespace, sign, digit or prefix
   function automatic logic [7:0] pick_stop_byte();
      logic [7:0] c;
      if ($urandom_range(0, 4) == 0) return 8'h00;
      do c = 8'($urandom_range(0, 255));
      while (c == CharSpace || (c >= CharTab && c <= CharCr) || c == CharMinus ||
             (c >= CharZero && c <= CharNine) || (c >= CharUpperA && c <= CharUpperF) ||
             (c >= CharLowerA && c <= CharLowerF) || c == CharLowerX || c == CharUpperX);
      return c;
   endfunction

   // Build a well-formed number with random content: whitespace, optional sign,
   // a decimal, hex, lone zero or missing body, and usually a stop byte.
   task automatic build_number_text(input int spaces, input bit always_stop);
      number_form_type form;
      logic [3:0]      nib;
      text_buf.delete();
      for (int i = 0; i < spaces; i++)
         text_buf.push_back($urandom_range(0, 5) == 0 ? CharSpace
                                                       : 8'($urandom_range(CharTab, CharCr)));
      if ($urandom_range(0, 99) < 35) text_buf.push_back(CharMinus);
      form = number_form_type'($urandom_range(0, 3));
      case (form)
         FormBare: ;
         FormDec: begin
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(8, 12) : $urandom_range(1, 4))
               text_buf.push_back(CharZero + 8'($urandom_range(0, 9)));
         end
         FormHex: begin
            text_buf.push_back(CharZero);
            text_buf.push_back($urandom_range(0, 1) ? CharLowerX : CharUpperX);
            repeat ($urandom_range(0, 10)) begin
               nib = 4'($urandom_range(0, 15));
               if (nib < 4'd10) text_buf.push_back(CharZero + 8'(nib));
               else text_buf.push_back(($urandom_range(0, 1) ? CharUpperA : CharLowerA)
                                       + 8'(nib) - 8'd10);
            end
         end
         default: text_buf.push_back(CharZero);
      endcase
      // Drop the stop byte now and then so the next parse restarts one in progress
      if (always_stop || $urandom_range(0, 9) != 0) text_buf.push_back(pick_stop_byte());
   endtask

   initial begin
      int milestone;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      calm       = 1'b0;
      hold_rsp   = 1'b0;
      gaps_on    = 1'b0;
      beats_sent = 0;
      milestone  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: a digit while idle is ignored
      send_beat(CharZero + 8'd5, 1'b0, 1'b0);
      // High byte and terminator as first byte: nothing found
      text_buf = '{8'h80};
      send_text();
      text_buf = '{8'h00};
      send_text();
      // Whitespace extremes, negative decimal, stop just above '9'
      text_buf = '{CharSpace, CharTab, CharCr, CharMinus, 8'h37, 8'h3A};
      send_text();
      // Lone sign, stop just below '0'
      text_buf = '{CharMinus, 8'h2F};
      send_text();
      // Empty hex, stop just below 'a'
      text_buf = '{CharZero, CharLowerX, 8'h60};
      send_text();
      // Hex letter extremes in both cases, stop just above 'F'
      text_buf = '{CharZero, CharUpperX, CharUpperF, CharLowerA, CharLowerF, CharUpperA, 8'h47};
      send_text();
      // Restart a parse in progress
      text_buf = '{8'h38};
      send_text();
      text_buf = '{8'h35, 8'hFF};
      send_text();
      // Leading zero then decimal; 'x' after a digit ends it
      text_buf = '{CharZero, CharNine, CharLowerX};
      send_text();
      // Byte after a result without restart: ignored
      send_beat(8'h33, 1'b0, 1'b0);

      while (beats_sent < TextBeats) begin
         gaps_on = $urandom_range(0, 1);
         calm    = beats_sent + CalmBeats >= TextBeats;
         if (milestone == 0 && beats_sent >= 150) begin
            // Hold off the receiver and keep offering one-byte parses for the whole
            // hold, so the result side fills and req stalls
            hold_rsp = 1'b1;
            while (hold_rsp) begin
               text_buf = '{pick_stop_byte()};
               send_text();
            end
            milestone++;
         end else if (milestone == 1 && beats_sent >= 300) begin
            // Pause the sender until every predicted result has drained
            req_valid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
            milestone++;
         end else if (milestone == 2 && beats_sent >= 400) begin
            // Long whitespace run drives used_count into saturation
            build_number_text(SaturateSpaces, 1'b1);
            send_text();
            milestone++;
         end else if ($urandom_range(0, 4) == 0) begin
            // Noise: raw bytes with random restart flags
            repeat ($urandom_range(1, 4))
               send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
         end else begin
            build_number_text($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0, 1'b0);
            send_text();
            if ($urandom_range(0, 7) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
      end

      // Drain: let the last beat reach the checker, then wait for every result
      req_valid <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < DrainLimit && outstanding != 0; n++) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
sv/aip_pkg.sv
sv/ascii_integer_parser_unit.sv
sv/aip_checker.sv
tb/sv/aip_result_checker.sv
tb/sv/ascii_integer_parser_unit_tb.sv
